### design/wood_ring_colorizer_defines.svh
// Shared assertion macros for the colorizer checker.
`ifndef WOOD_RING_COLORIZER_DEFINES_SVH
`define WOOD_RING_COLORIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled in reset.
`define WRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wrc assertion failed");

// Next-cycle implication, sampled on clk, disabled in reset.
`define WRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wrc assertion failed");

`endif

### design/wrc_pkg.sv
package wrc_pkg;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_SINE  = 2'd1;
  localparam logic [1:0] MODE_COS   = 2'd2;
  localparam logic [1:0] MODE_INV   = 2'd3;

  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_RING_SCALE = 3'd1;
  localparam logic [2:0] REG_BG_RED     = 3'd2;
  localparam logic [2:0] REG_BG_GREEN   = 3'd3;
  localparam logic [2:0] REG_BG_BLUE    = 3'd4;
  localparam logic [2:0] REG_DIFF_RED   = 3'd5;
  localparam logic [2:0] REG_DIFF_GREEN = 3'd6;
  localparam logic [2:0] REG_DIFF_BLUE  = 3'd7;

  localparam logic [31:0] DIV_NUM    = 32'h1000_0000;
  localparam int          DIV_STAGES = 8;
  localparam int          DIV_STEPS  = 4;
  localparam int          DEN_W      = 22;
  localparam int          QUO_W      = 24;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef logic [16:0] weight_t;

endpackage

### design/wrc_div.sv
module wrc_div import wrc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic [DEN_W-1:0]         denom,
  input  logic signed [15:0]       in_noise,
  output logic                     out_valid,
  output logic [QUO_W-1:0]         quot,
  output logic signed [15:0]       out_noise
);

  logic                   v_r [0:DIV_STAGES-1];
  logic [DEN_W-1:0]       d_r [0:DIV_STAGES-1];
  logic [DEN_W-1:0]       r_r [0:DIV_STAGES-1];
  logic [QUO_W-1:0]       q_r [0:DIV_STAGES-1];
  logic signed [15:0]     n_r [0:DIV_STAGES-1];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic               v_src;
    logic [DEN_W-1:0]   d_src;
    logic [DEN_W-1:0]   r_src;
    logic [QUO_W-1:0]   q_src;
    logic signed [15:0] n_src;
    logic [DEN_W-1:0]   r_next;
    logic [QUO_W-1:0]   q_next;

    if (s == 0) begin : g_first
      assign v_src = in_valid;
      assign d_src = denom;
      assign r_src = '0;
      assign q_src = '0;
      assign n_src = in_noise;
    end else begin : g_rest
      assign v_src = v_r[s-1];
      assign d_src = d_r[s-1];
      assign r_src = r_r[s-1];
      assign q_src = q_r[s-1];
      assign n_src = n_r[s-1];
    end

    always_comb begin
      logic [DEN_W:0] rt;
      r_next = r_src;
      q_next = q_src;
      for (int j = 0; j < DIV_STEPS; j++) begin
        rt = {r_next, DIV_NUM[31 - (s * DIV_STEPS + j)]};
        if (rt >= {1'b0, d_src}) begin
          rt = rt - {1'b0, d_src};
          q_next = {q_next[QUO_W-2:0], 1'b1};
        end else begin
          q_next = {q_next[QUO_W-2:0], 1'b0};
        end
        r_next = rt[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[s] <= 1'b0;
      end else if (adv) begin
        v_r[s] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_r[s] <= d_src;
        r_r[s] <= r_next;
        q_r[s] <= q_next;
        n_r[s] <= n_src;
      end
    end
  end

  assign out_valid = v_r[DIV_STAGES-1];
  assign quot      = q_r[DIV_STAGES-1];
  assign out_noise = n_r[DIV_STAGES-1];

endmodule

### design/wrc_wave.sv
module wrc_wave import wrc_pkg::*; #(
  parameter int SINE_TABLE_STEPS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [1:0]  mode,
  input  logic [15:0] f,
  output logic        out_valid,
  output weight_t     weight
);

  localparam int IW    = $clog2(SINE_TABLE_STEPS + 1);
  localparam int POS_W = 16 + IW;

  function automatic logic [63:0] udiv(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [16:0] taylor(int unsigned k, bit odd);
    logic [63:0]        a30;
    logic [63:0]        a2;
    logic [63:0]        term;
    logic [63:0]        d;
    logic [63:0]        r;
    logic signed [63:0] sum;
    a30  = udiv(64'(k) << 30, 64'(SINE_TABLE_STEPS));
    a2   = (a30 * a30) >> 30;
    term = odd ? a30 : (64'd1 << 30);
    sum  = $signed(term);
    for (int i = 0; i < 15; i++) begin
      d    = odd ? 64'((2 * i + 2) * (2 * i + 3)) : 64'((2 * i + 1) * (2 * i + 2));
      term = udiv((term * a2) >> 30, d);
      if (i[0] == 1'b0) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    r = ($unsigned(sum) + 64'd8192) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    return r[16:0];
  endfunction

  logic [16:0] sin_tab [0:SINE_TABLE_STEPS];
  logic [16:0] cos_tab [0:SINE_TABLE_STEPS];

  for (genvar k = 0; k <= SINE_TABLE_STEPS; k++) begin : g_tab
    localparam logic [16:0] SV = taylor(k, 1'b1);
    localparam logic [16:0] CV = taylor(k, 1'b0);
    assign sin_tab[k] = SV;
    assign cos_tab[k] = CV;
  end

  logic              v_p, v_t, v_i, v_w;
  logic [POS_W-1:0]  pos;
  logic [15:0]       f_p, f_t, f_i;
  logic [16:0]       lo_t, hi_t, lo_i;
  logic [15:0]       fr_t;
  logic [16:0]       term_i;
  logic              up_i;
  logic [IW-1:0]     idx;
  logic [IW-1:0]     idx_hi;
  logic [16:0]       delta;
  logic [32:0]       prod;
  logic [16:0]       g;
  logic [17:0]       t_sum;
  weight_t           t_next;

  assign idx    = pos[16 +: IW];
  assign idx_hi = idx + IW'(1);
  assign delta  = (hi_t >= lo_t) ? hi_t - lo_t : lo_t - hi_t;
  assign prod   = delta * fr_t;

  always_comb begin
    if (mode == MODE_PLAIN) begin
      g = {1'b0, f_i};
    end else if (up_i) begin
      g = lo_i + term_i;
    end else begin
      g = lo_i - term_i;
    end
    t_sum  = ({1'b0, ONE_Q16} + {1'b0, g}) >> 1;
    t_next = (t_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : t_sum[16:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p <= 1'b0;
      v_t <= 1'b0;
      v_i <= 1'b0;
      v_w <= 1'b0;
    end else if (adv) begin
      v_p <= in_valid;
      v_t <= v_p;
      v_i <= v_t;
      v_w <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos    <= {{IW{1'b0}}, f} * POS_W'(SINE_TABLE_STEPS);
      f_p    <= f;
      lo_t   <= (mode == MODE_COS) ? cos_tab[idx] : sin_tab[idx];
      hi_t   <= (mode == MODE_COS) ? cos_tab[idx_hi] : sin_tab[idx_hi];
      fr_t   <= pos[15:0];
      f_t    <= f_p;
      lo_i   <= lo_t;
      term_i <= prod[32:16];
      up_i   <= hi_t >= lo_t;
      f_i    <= f_t;
      weight <= t_next;
    end
  end

  assign out_valid = v_w;

endmodule

### design/wood_ring_colorizer.sv
// Beats pass the input, divider, scale, wave and color registers in order.
// Throughput: one beat per cycle; every stage is a register and a stall
// freezes the whole pipeline (8 of the stages form the reciprocal divider).
// Reset (rst, synchronous, active high) empties the pipeline and loads the
// registers with mode plain, ring scale 8.0, zero background and difference.
module wood_ring_colorizer import wrc_pkg::*; #(
  parameter int SINE_TABLE_STEPS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] noise,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output weight_t            weight,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [1:0]        mode;
  logic [15:0]       ring_scale;
  logic [7:0]        bg [0:2];
  logic signed [8:0] diff [0:2];

  logic adv;
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_PLAIN;
      ring_scale <= 16'd2048;
      for (int c = 0; c < 3; c++) begin
        bg[c]   <= '0;
        diff[c] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:       mode       <= cfg_data[1:0];
        REG_RING_SCALE: ring_scale <= cfg_data;
        REG_BG_RED:     bg[0]      <= cfg_data[7:0];
        REG_BG_GREEN:   bg[1]      <= cfg_data[7:0];
        REG_BG_BLUE:    bg[2]      <= cfg_data[7:0];
        REG_DIFF_RED:   diff[0]    <= cfg_data[8:0];
        REG_DIFF_GREEN: diff[1]    <= cfg_data[8:0];
        REG_DIFF_BLUE:  diff[2]    <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  logic               v_a;
  logic signed [15:0] n_a;
  logic [DEN_W-1:0]   d_a;
  logic [16:0]        mag;

  assign mag = noise[15] ? 17'd0 - {noise[15], noise} : {1'b0, noise};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else if (adv) begin
      v_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_a <= noise;
      d_a <= {{(DEN_W-17){1'b0}}, mag} * DEN_W'(100);
    end
  end

  logic               v_d;
  logic [QUO_W-1:0]   quot;
  logic signed [15:0] n_d;

  wrc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v_a),
    .denom     (d_a),
    .in_noise  (n_a),
    .out_valid (v_d),
    .quot      (quot),
    .out_noise (n_d)
  );

  logic             v_m;
  logic [15:0]      f_m;
  logic [QUO_W-1:0] x24;
  logic [23:0]      p;

  assign x24 = (mode == MODE_INV) ? quot : {{4{n_d[15]}}, n_d, 4'b0000};
  assign p   = x24 * {8'd0, ring_scale};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m <= 1'b0;
    end else if (adv) begin
      v_m <= v_d;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_m <= p[23:8];
    end
  end

  logic    v_w;
  weight_t t_w;

  wrc_wave #(
    .SINE_TABLE_STEPS (SINE_TABLE_STEPS)
  ) u_wave (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v_m),
    .mode      (mode),
    .f         (f_m),
    .out_valid (v_w),
    .weight    (t_w)
  );

  logic               v_c;
  weight_t            t_c;
  logic signed [26:0] prod_c [0:2];
  logic [7:0]         col_next [0:2];

  always_comb begin
    logic signed [10:0] q;
    logic signed [11:0] s;
    for (int c = 0; c < 3; c++) begin
      q = prod_c[c][26:16];
      s = $signed({4'b0000, bg[c]}) + 12'(q);
      if (s < 0) col_next[c] = 8'd0;
      else if (s > 12'sd255) col_next[c] = 8'd255;
      else col_next[c] = s[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v_c       <= v_w;
      out_valid <= v_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        prod_c[c] <= $signed({{18{diff[c][8]}}, diff[c]}) * $signed({10'd0, t_w});
      end
      t_c    <= t_w;
      red    <= col_next[0];
      green  <= col_next[1];
      blue   <= col_next[2];
      weight <= t_c;
    end
  end

endmodule

### design/wrc_checker.sv
`include "wood_ring_colorizer_defines.svh"

module wrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [15:0] noise,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  red,
  input logic [7:0]  green,
  input logic [7:0]  blue,
  input logic [16:0] weight,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index,
  input logic [15:0] cfg_data
);

  `WRC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(red) && $stable(green) && $stable(blue) && $stable(weight))
  `WRC_ASSERT_NOW(a_back_pressure, 1'b1, in_stall == (out_valid && out_stall))
  `WRC_ASSERT_NOW(a_weight_range, out_valid, weight <= 17'd65536)
  `WRC_ASSERT_NOW(a_reset_empty, $past(rst), !out_valid)

endmodule

bind wood_ring_colorizer wrc_checker u_wrc_checker (.*);
